// ----- rtl/core/assert_macros.svh -----
// assertion macros used by tick_task_release_table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define TTRT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen outside reset
`define TTRT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TTRT_ASSERT(lbl, clk, rst_n, prop, msg)
`define TTRT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/core/ttrt_pkg.sv -----
// shared types and constants of the tick task release table
`timescale 1ns / 1ps
package ttrt_pkg;

  // input opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  // field widths
  localparam int unsigned TAG_W    = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned REP_W    = 4;

  // most results a single tick reports
  localparam logic [REP_W-1:0] RES_LIMIT = 4'd8;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_OK  = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_IDLE    = 2'd3
  } kind_e;

  // one table entry
  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] countdown;
  } entry_t;

  // one result beat
  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
  } result_t;

endpackage

// ----- rtl/core/ttrt_in_if.sv -----
// input channel: opcode, task tag and period with valid/ready
`timescale 1ns / 1ps
interface ttrt_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  task_tag;
  logic [15:0] period;

  modport source (output valid, output opcode, output task_tag, output period, input ready);
  modport sink   (input valid, input opcode, input task_tag, input period, output ready);
endinterface

// ----- rtl/core/ttrt_out_if.sv -----
// output channel: result kind, slot, tag and last flag with valid/ready
`timescale 1ns / 1ps
interface ttrt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [2:0] slot;
  logic [7:0] released_tag;
  logic       last;

  modport source (output valid, output result_kind, output slot, output released_tag,
                  output last, input ready);
  modport sink   (input valid, input result_kind, input slot, input released_tag,
                  input last, output ready);
endinterface

// ----- rtl/core/ttrt_table.sv -----
// task table storage: tag, period and countdown memories, one read and one write port
`timescale 1ns / 1ps
module ttrt_table #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned IDX_W = 3
) (
  input  logic              clk_i,
  input  logic              wr_all_i,
  input  logic              wr_cd_i,
  input  logic [IDX_W-1:0]  wr_idx_i,
  input  ttrt_pkg::entry_t  wr_entry_i,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_idx_i,
  output ttrt_pkg::entry_t  rd_entry_o
);

  logic [ttrt_pkg::TAG_W-1:0]    tag_mem    [DEPTH];
  logic [ttrt_pkg::PERIOD_W-1:0] period_mem [DEPTH];
  logic [ttrt_pkg::PERIOD_W-1:0] cd_mem     [DEPTH];
  ttrt_pkg::entry_t              rd_entry_q;

  // writes: add fills a whole entry, the walk rewrites only the countdown
  always_ff @(posedge clk_i) begin
    if (wr_all_i) begin
      tag_mem[wr_idx_i]    <= wr_entry_i.tag;
      period_mem[wr_idx_i] <= wr_entry_i.period;
    end
    if (wr_all_i || wr_cd_i) begin
      cd_mem[wr_idx_i] <= wr_entry_i.countdown;
    end
  end

  // registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_entry_q.tag       <= tag_mem[rd_idx_i];
      rd_entry_q.period    <= period_mem[rd_idx_i];
      rd_entry_q.countdown <= cd_mem[rd_idx_i];
    end
  end

  assign rd_entry_o = rd_entry_q;

endmodule

// ----- rtl/core/tick_task_release_table.sv -----
// Add: the result is held in the pending register, then loaded into the output register once it is free.
// Tick: one entry is visited per cycle through the table's single read port while the
//   output side does not stall; the final result is loaded once the walk has finished
//   and the output register is free.
// One item is worked on at a time; the next beat is taken once the last result is queued.
// Reset clears the task count and control state; table memories are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tick_task_release_table #(
  parameter int unsigned MAX_TASKS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ttrt_in_if.sink      in_i,
  ttrt_out_if.source   out_o
);

  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [CNT_W-1:0]           rd_addr_q, rd_addr_d;
  logic                       ev_valid_q, ev_valid_d;
  logic [IDX_W-1:0]           ev_idx_q, ev_idx_d;
  logic [ttrt_pkg::REP_W-1:0] rep_cnt_q, rep_cnt_d;
  logic                       pend_valid_q, pend_valid_d;
  ttrt_pkg::result_t          pend_q, pend_d;
  logic                       out_valid_q, out_valid_d;
  ttrt_pkg::result_t          out_res_q, out_res_d;
  logic                       out_last_q, out_last_d;

  logic                       out_free;
  logic                       push;
  logic                       ev_zero;
  logic                       ev_report;
  logic                       need_push;
  logic                       advance;
  logic                       rd_en;
  logic                       wr_all;
  logic                       wr_cd;
  logic [IDX_W-1:0]           wr_idx;
  ttrt_pkg::entry_t           wr_entry;
  ttrt_pkg::entry_t           rd_entry;
  logic [ttrt_pkg::PERIOD_W-1:0] cd_next;

  // table storage
  ttrt_table #(
    .DEPTH (MAX_TASKS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i      (clk_i),
    .wr_all_i   (wr_all),
    .wr_cd_i    (wr_cd),
    .wr_idx_i   (wr_idx),
    .wr_entry_i (wr_entry),
    .rd_en_i    (rd_en),
    .rd_idx_i   (rd_addr_q[IDX_W-1:0]),
    .rd_entry_o (rd_entry)
  );

  // shared countdown unit: zero test, then reload or decrement
  assign ev_zero = (rd_entry.countdown == '0);
  assign cd_next = ev_zero ? rd_entry.period : rd_entry.countdown - 16'd1;

  // walk control
  assign out_free  = !out_valid_q || out_o.ready;
  assign ev_report = ev_valid_q && ev_zero && (rep_cnt_q < ttrt_pkg::RES_LIMIT);
  assign need_push = ev_report && pend_valid_q;
  assign advance   = (state_q == ST_WALK) && !(need_push && !out_free);
  assign rd_en     = advance && (rd_addr_q < count_q);

  assign in_i.ready = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_addr_d    = rd_addr_q;
    ev_valid_d   = ev_valid_q;
    ev_idx_d     = ev_idx_q;
    rep_cnt_d    = rep_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    push         = 1'b0;
    out_res_d    = out_res_q;
    out_last_d   = out_last_q;
    wr_all       = 1'b0;
    wr_cd        = 1'b0;
    wr_idx       = ev_idx_q;
    wr_entry.tag       = in_i.task_tag;
    wr_entry.period    = in_i.period;
    wr_entry.countdown = cd_next;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.opcode == ttrt_pkg::OP_ADD) begin
            pend_valid_d = 1'b1;
            state_d      = ST_FLUSH;
            if (count_q < MAX_CNT) begin
              wr_all             = 1'b1;
              wr_idx             = count_q[IDX_W-1:0];
              wr_entry.countdown = in_i.period;
              pend_d.kind        = ttrt_pkg::KIND_ADD_OK;
              pend_d.slot        = ttrt_pkg::SLOT_W'(count_q[IDX_W-1:0]);
              pend_d.tag         = in_i.task_tag;
              count_d            = count_q + 1'b1;
            end else begin
              pend_d.kind = ttrt_pkg::KIND_FULL;
              pend_d.slot = '0;
              pend_d.tag  = '0;
            end
          end else begin
            rd_addr_d    = '0;
            ev_valid_d   = 1'b0;
            rep_cnt_d    = '0;
            pend_valid_d = 1'b0;
            state_d      = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (advance) begin
          // retire the entry in the read register
          if (ev_valid_q) begin
            wr_cd = 1'b1;
            if (ev_report) begin
              if (pend_valid_q) begin
                push       = 1'b1;
                out_res_d  = pend_q;
                out_last_d = 1'b0;
              end
              pend_valid_d = 1'b1;
              pend_d.kind  = ttrt_pkg::KIND_RELEASE;
              pend_d.slot  = ttrt_pkg::SLOT_W'(ev_idx_q);
              pend_d.tag   = rd_entry.tag;
              rep_cnt_d    = rep_cnt_q + 1'b1;
            end
          end
          // fetch the next entry
          ev_valid_d = rd_en;
          if (rd_en) begin
            ev_idx_d  = rd_addr_q[IDX_W-1:0];
            rd_addr_d = rd_addr_q + 1'b1;
          end
          if (!ev_valid_q && !rd_en) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push       = 1'b1;
          out_last_d = 1'b1;
          if (pend_valid_q) begin
            out_res_d = pend_q;
          end else begin
            out_res_d.kind = ttrt_pkg::KIND_IDLE;
            out_res_d.slot = '0;
            out_res_d.tag  = '0;
          end
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      rd_addr_q    <= '0;
      ev_valid_q   <= 1'b0;
      rep_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      rd_addr_q    <= rd_addr_d;
      ev_valid_q   <= ev_valid_d;
      rep_cnt_q    <= rep_cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ev_idx_q <= ev_idx_d;
    pend_q   <= pend_d;
    if (push) begin
      out_res_q  <= out_res_d;
      out_last_q <= out_last_d;
    end
  end

  // output beat
  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = out_res_q.kind;
  assign out_o.slot         = out_res_q.slot;
  assign out_o.released_tag = out_res_q.tag;
  assign out_o.last         = out_last_q;

  // checks
  `TTRT_NEVER(a_count_range, clk_i, rst_ni, count_q > MAX_CNT, "task count beyond table size")
  `TTRT_NEVER(a_rep_range, clk_i, rst_ni, rep_cnt_q > ttrt_pkg::RES_LIMIT, "too many releases reported")
  `TTRT_ASSERT(a_walk_pend, clk_i, rst_ni, (state_q == ST_WALK && pend_valid_q) |-> (pend_q.kind == ttrt_pkg::KIND_RELEASE), "pending walk result is not a release")
  `TTRT_ASSERT(a_ev_walk, clk_i, rst_ni, ev_valid_q |-> (state_q == ST_WALK), "entry under evaluation outside walk")

endmodule
